// File: sv/pfe_pkg.sv
// Shared types, constants and handshake structs of the Playfair encryptor.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
   localparam int ALPHABET    = 26;
   localparam int LETTER_W    = 5;
   localparam int LETTER_PAD  = (2 ** LETTER_W) - ALPHABET;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int COORD_W     = $clog2(SQUARE_SIDE);
   localparam int FILL_W      = $clog2(CELLS + 1);
   localparam int SCAN_W      = $clog2(ALPHABET + 1);

   localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
   localparam logic [LETTER_W-1:0] LETTER_Q = LETTER_W'(16);
   localparam logic [LETTER_W-1:0] LETTER_X = LETTER_W'(23);

   typedef enum logic [1:0] {
      CMD_KEY     = 2'd0,
      CMD_KEY_END = 2'd1,
      CMD_MSG     = 2'd2,
      CMD_MSG_END = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first_cipher;
      logic [LETTER_W-1:0] second_cipher;
      logic                bad_letter;
   } rsp_type;

   // What the latched word asks the datapath to do.
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_PLACE = 3'd1,
      ACT_FILL  = 3'd2,
      ACT_PAIR  = 3'd3,
      ACT_BAD   = 3'd4,
      ACT_HOLD  = 3'd5
   } act_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic fill_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      act_type act;
      logic    fill_done;
      logic    out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: sv/playfair_encryptor.sv
// Top level of the Playfair encryptor: controller plus datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data  (cmd, letter)
//   rsp      out        rsp_valid/rsp_ready   rsp_data  (first_cipher, second_cipher, bad_letter)
//
// One word at a time. Key letter, held message letter or ignored word: latch, then decode.
// Key end: latch, decode, then the fill sweep, one letter a cycle.
// Enciphered digraph: latch, decode, position memory read, square memory read, emit;
// a dropped J: latch, decode, emit. A full result register stalls the word in its emit state.
// Reset (synchronous, active high) empties the square and clears pending state; no sweep.
// The next word is taken while a result waits on rsp; only a second result must wait.
`timescale 1ns / 1ps
`default_nettype none

module playfair_encryptor (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pfe_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pfe_pkg::rsp_type       rsp_data
);

   // Commands down to the datapath, status back up.
   pfe_pkg::dp_cmd_type  dp_cmd;
   pfe_pkg::dp_stat_type dp_stat;

   // Sequence each word: latch, decode, then sweep, look up or emit.
   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // Hold the square, positions and pending letter; drive the result register.
   pfe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

endmodule

`default_nettype wire

// File: sv/pfe_datapath.sv
// Datapath: key square, letter positions, pending letter, digraph lookup and result register.
`timescale 1ns / 1ps
`default_nettype none

module pfe_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pfe_pkg::req_type     req_data,
   output pfe_pkg::rsp_type          rsp_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire pfe_pkg::dp_cmd_type  cmd,
   output pfe_pkg::dp_stat_type      stat
);

   localparam int COORD_W  = pfe_pkg::COORD_W;
   localparam int LETTER_W = pfe_pkg::LETTER_W;
   localparam int CELL_W   = pfe_pkg::CELL_W;
   localparam int FILL_W   = pfe_pkg::FILL_W;
   localparam int SCAN_W   = pfe_pkg::SCAN_W;
   localparam int POS_W    = 2 * COORD_W;

   function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v == COORD_W'(pfe_pkg::SQUARE_SIDE - 1)) begin
         r = '0;
      end else begin
         r = v + COORD_W'(1);
      end
      return r;
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
      logic [CELL_W-1:0] r;
      r = CELL_W'(CELL_W'(row) * CELL_W'(pfe_pkg::SQUARE_SIDE) + CELL_W'(col));
      return r;
   endfunction

   logic [1:0]                    item_cmd_ff, item_cmd_in;
   logic [LETTER_W-1:0]           item_letter_ff, item_letter_in;
   logic [FILL_W-1:0]             fill_count_ff, fill_count_in;
   logic [COORD_W-1:0]            fill_row_ff, fill_row_in;
   logic [COORD_W-1:0]            fill_col_ff, fill_col_in;
   logic [pfe_pkg::ALPHABET-1:0]  letter_used_ff, letter_used_in;
   logic [SCAN_W-1:0]             scan_ff, scan_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0]           pend_letter_ff, pend_letter_in;
   logic [LETTER_W-1:0]           pair_a_ff, pair_a_in;
   logic [LETTER_W-1:0]           pair_b_ff, pair_b_in;
   logic                          result_bad_ff, result_bad_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic [LETTER_W-1:0] square_mem [pfe_pkg::CELLS];
   logic [POS_W-1:0]    pos_mem [pfe_pkg::ALPHABET];
   logic [POS_W-1:0]    pos_a_ff, pos_b_ff;
   logic [LETTER_W-1:0] sq_a_ff, sq_b_ff;

   logic [(2 ** LETTER_W)-1:0] used_ext;
   logic                       full;
   logic                       msg_bad;
   logic                       fill_done;
   pfe_pkg::act_type           act;
   logic                       place_en;
   logic [LETTER_W-1:0]        place_letter;
   logic [COORD_W-1:0]         ra, ca, rb, cb;
   logic [CELL_W-1:0]          na, nb;

   // Letters beyond Z read as already used.
   assign used_ext  = {{pfe_pkg::LETTER_PAD{1'b1}}, letter_used_ff};
   assign full      = (fill_count_ff == FILL_W'(pfe_pkg::CELLS));
   assign msg_bad   = (item_letter_ff >= LETTER_W'(pfe_pkg::ALPHABET)) ||
                      (item_letter_ff == pfe_pkg::LETTER_J);
   assign fill_done = (scan_ff == SCAN_W'(pfe_pkg::ALPHABET)) || full;

   always_comb begin
      unique case (pfe_pkg::cmd_type'(item_cmd_ff))
         pfe_pkg::CMD_KEY: begin
            act = (!full && !used_ext[item_letter_ff]) ? pfe_pkg::ACT_PLACE : pfe_pkg::ACT_NONE;
         end
         pfe_pkg::CMD_KEY_END: begin
            act = pfe_pkg::ACT_FILL;
         end
         pfe_pkg::CMD_MSG: begin
            if (!full) begin
               act = pfe_pkg::ACT_NONE;
            end else if (msg_bad) begin
               act = pfe_pkg::ACT_BAD;
            end else if (!pend_valid_ff) begin
               act = pfe_pkg::ACT_HOLD;
            end else begin
               act = pfe_pkg::ACT_PAIR;
            end
         end
         pfe_pkg::CMD_MSG_END: begin
            act = (full && pend_valid_ff) ? pfe_pkg::ACT_PAIR : pfe_pkg::ACT_NONE;
         end
         default: begin
            act = pfe_pkg::ACT_NONE;
         end
      endcase
   end

   assign place_en = (cmd.decode && (act == pfe_pkg::ACT_PLACE)) ||
                     (cmd.fill_step && !fill_done && !used_ext[scan_ff]);
   assign place_letter = cmd.fill_step ? LETTER_W'(scan_ff) : item_letter_ff;

   always_comb begin
      item_cmd_in    = item_cmd_ff;
      item_letter_in = item_letter_ff;
      fill_count_in  = fill_count_ff;
      fill_row_in    = fill_row_ff;
      fill_col_in    = fill_col_ff;
      letter_used_in = letter_used_ff;
      scan_in        = scan_ff;
      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      pair_a_in      = pair_a_ff;
      pair_b_in      = pair_b_ff;
      result_bad_in  = result_bad_ff;

      if (cmd.latch) begin
         item_cmd_in    = req_data.cmd;
         item_letter_in = req_data.letter;
      end

      if (place_en) begin
         fill_count_in = fill_count_ff + FILL_W'(1);
         letter_used_in[place_letter] = 1'b1;
         if (fill_col_ff == COORD_W'(pfe_pkg::SQUARE_SIDE - 1)) begin
            fill_col_in = '0;
            fill_row_in = fill_row_ff + COORD_W'(1);
         end else begin
            fill_col_in = fill_col_ff + COORD_W'(1);
         end
      end

      if (cmd.fill_step && !fill_done) begin
         scan_in = scan_ff + SCAN_W'(1);
      end

      if (cmd.decode) begin
         result_bad_in = (act == pfe_pkg::ACT_BAD);
         if (act == pfe_pkg::ACT_FILL) begin
            scan_in = '0;
         end
         if (act == pfe_pkg::ACT_HOLD) begin
            pend_letter_in = item_letter_ff;
            pend_valid_in  = 1'b1;
         end
         if (act == pfe_pkg::ACT_PAIR) begin
            pair_a_in = pend_letter_ff;
            if (item_cmd_ff == pfe_pkg::CMD_MSG_END) begin
               pair_b_in     = pfe_pkg::LETTER_X;
               pend_valid_in = 1'b0;
            end else if (item_letter_ff != pend_letter_ff) begin
               pair_b_in     = item_letter_ff;
               pend_valid_in = 1'b0;
            end else begin
               // Doubled letter: pad it and keep it pending.
               pair_b_in = (pend_letter_ff == pfe_pkg::LETTER_X) ? pfe_pkg::LETTER_Q
                                                                 : pfe_pkg::LETTER_X;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff  <= '0;
         fill_row_ff    <= '0;
         fill_col_ff    <= '0;
         letter_used_ff <= pfe_pkg::ALPHABET'(1) << pfe_pkg::LETTER_J;
         scan_ff        <= '0;
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         result_bad_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fill_count_ff  <= fill_count_in;
         fill_row_ff    <= fill_row_in;
         fill_col_ff    <= fill_col_in;
         letter_used_ff <= letter_used_in;
         scan_ff        <= scan_in;
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
         result_bad_ff  <= result_bad_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff    <= item_cmd_in;
      item_letter_ff <= item_letter_in;
      pair_a_ff      <= pair_a_in;
      pair_b_ff      <= pair_b_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Position memory: one write port, two registered reads.
   always_ff @(posedge clock) begin
      if (place_en) begin
         pos_mem[place_letter] <= {fill_row_ff, fill_col_ff};
      end
      pos_a_ff <= pos_mem[pair_a_ff];
      pos_b_ff <= pos_mem[pair_b_ff];
   end

   assign ra = pos_a_ff[POS_W-1:COORD_W];
   assign ca = pos_a_ff[COORD_W-1:0];
   assign rb = pos_b_ff[POS_W-1:COORD_W];
   assign cb = pos_b_ff[COORD_W-1:0];

   always_comb begin
      if (ra == rb) begin
         na = cell_of(ra, wrap_inc(ca));
         nb = cell_of(rb, wrap_inc(cb));
      end else if (ca == cb) begin
         na = cell_of(wrap_inc(ra), ca);
         nb = cell_of(wrap_inc(rb), cb);
      end else begin
         na = cell_of(ra, cb);
         nb = cell_of(rb, ca);
      end
   end

   // Square memory: one write port, two registered reads.
   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_count_ff[CELL_W-1:0]] <= place_letter;
      end
      sq_a_ff <= square_mem[na];
      sq_b_ff <= square_mem[nb];
   end

   assign stat.act       = act;
   assign stat.fill_done = fill_done;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (result_bad_ff) begin
            rsp_data_in.first_cipher  = '0;
            rsp_data_in.second_cipher = '0;
            rsp_data_in.bad_letter    = 1'b1;
         end else begin
            rsp_data_in.first_cipher  = sq_a_ff;
            rsp_data_in.second_cipher = sq_b_ff;
            rsp_data_in.bad_letter    = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_used_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(letter_used_ff) == int'(fill_count_ff) + 1)
      else $error("letter_used count out of step with fill count");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result appeared without an emit command");

   a_fill_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (fill_count_ff <= FILL_W'(pfe_pkg::CELLS)))
      else $error("fill step past a complete square");
`endif

endmodule

`default_nettype wire

// File: sv/pfe_ctrl.sv
// Controller state machine: sequences decode, fill sweep, lookups and result emission.
`timescale 1ns / 1ps
`default_nettype none

module pfe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output pfe_pkg::dp_cmd_type        cmd,
   input  wire pfe_pkg::dp_stat_type  stat
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_FILL   = 6'b000100,
      ST_LOOKUP = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            unique case (stat.act)
               pfe_pkg::ACT_FILL: state_in = ST_FILL;
               pfe_pkg::ACT_PAIR: state_in = ST_LOOKUP;
               pfe_pkg::ACT_BAD:  state_in = ST_EMIT;
               default:           state_in = ST_IDLE;
            endcase
         end
         ST_FILL: begin
            if (stat.fill_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded next cycle");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("emit while result register still occupied");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");
`endif

endmodule

`default_nettype wire

// File: test/playfair_encryptor_checker.sv
// Checker for the Playfair encryptor: predicts each digraph result and compares it on rsp.
`timescale 1ns / 1ps

module playfair_encryptor_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire pfe_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire pfe_pkg::rsp_type rsp_data,
   output int                    error_count,
   output int                    results_waiting,
   output int                    results_checked,
   output int                    flagged_seen
);

   // Own copy of the key square and the message state.
   logic [pfe_pkg::LETTER_W-1:0] cipher_sq [pfe_pkg::CELLS];
   logic [pfe_pkg::LETTER_W-1:0] cell_of [pfe_pkg::ALPHABET];
   logic [pfe_pkg::ALPHABET-1:0] placed;
   int                           cells_filled;
   logic [pfe_pkg::LETTER_W-1:0] held_letter;
   logic                         held_valid;

   pfe_pkg::rsp_type expected_pairs [$];

   initial begin
      error_count     = 0;
      results_waiting = 0;
      results_checked = 0;
      flagged_seen    = 0;
   end

   task automatic place_letter(logic [pfe_pkg::LETTER_W-1:0] l);
      cipher_sq[cells_filled] = l;
      cell_of[l]              = pfe_pkg::LETTER_W'(cells_filled);
      placed[l]               = 1'b1;
      cells_filled++;
   endtask

   task automatic queue_result(pfe_pkg::rsp_type r);
      expected_pairs = {expected_pairs, r};
   endtask

   function automatic pfe_pkg::rsp_type cipher_pair(logic [pfe_pkg::LETTER_W-1:0] a,
                                                    logic [pfe_pkg::LETTER_W-1:0] b);
      int               pa, pb, ra, ca, rb, cb, na, nb;
      pfe_pkg::rsp_type r;
      pa = cell_of[a];
      pb = cell_of[b];
      ra = pa / pfe_pkg::SQUARE_SIDE;
      ca = pa % pfe_pkg::SQUARE_SIDE;
      rb = pb / pfe_pkg::SQUARE_SIDE;
      cb = pb % pfe_pkg::SQUARE_SIDE;
      if (ra == rb) begin
         na = ra * pfe_pkg::SQUARE_SIDE + (ca + 1) % pfe_pkg::SQUARE_SIDE;
         nb = rb * pfe_pkg::SQUARE_SIDE + (cb + 1) % pfe_pkg::SQUARE_SIDE;
      end else if (ca == cb) begin
         na = ((ra + 1) % pfe_pkg::SQUARE_SIDE) * pfe_pkg::SQUARE_SIDE + ca;
         nb = ((rb + 1) % pfe_pkg::SQUARE_SIDE) * pfe_pkg::SQUARE_SIDE + cb;
      end else begin
         na = ra * pfe_pkg::SQUARE_SIDE + cb;
         nb = rb * pfe_pkg::SQUARE_SIDE + ca;
      end
      r.first_cipher  = cipher_sq[na];
      r.second_cipher = cipher_sq[nb];
      r.bad_letter    = 1'b0;
      return r;
   endfunction

   task automatic predict_word(pfe_pkg::req_type w);
      pfe_pkg::cmd_type             c;
      logic [pfe_pkg::LETTER_W-1:0] l;
      bit                           full;
      c    = pfe_pkg::cmd_type'(w.cmd);
      l    = w.letter;
      full = cells_filled >= pfe_pkg::CELLS;
      case (c)
         pfe_pkg::CMD_KEY: begin
            if (l < pfe_pkg::ALPHABET && !full && !placed[l]) place_letter(l);
         end
         pfe_pkg::CMD_KEY_END: begin
            for (int i = 0; i < pfe_pkg::ALPHABET; i++)
               if (cells_filled < pfe_pkg::CELLS && !placed[i])
                  place_letter(pfe_pkg::LETTER_W'(i));
         end
         pfe_pkg::CMD_MSG_END: begin
            if (full && held_valid) begin
               queue_result(cipher_pair(held_letter, pfe_pkg::LETTER_X));
               held_valid = 1'b0;
            end
         end
         pfe_pkg::CMD_MSG: begin
            if (full) begin
               if (l >= pfe_pkg::ALPHABET || l == pfe_pkg::LETTER_J) begin
                  queue_result(pfe_pkg::rsp_type'{first_cipher: '0, second_cipher: '0,
                                                  bad_letter: 1'b1});
               end else if (!held_valid) begin
                  held_letter = l;
                  held_valid  = 1'b1;
               end else if (l != held_letter) begin
                  queue_result(cipher_pair(held_letter, l));
                  held_valid = 1'b0;
               end else if (held_letter != pfe_pkg::LETTER_X) begin
                  // doubled letter: pad with X, keep the letter held
                  queue_result(cipher_pair(held_letter, pfe_pkg::LETTER_X));
               end else begin
                  queue_result(cipher_pair(pfe_pkg::LETTER_X, pfe_pkg::LETTER_Q));
               end
            end
         end
      endcase
   endtask

   task automatic check_result(pfe_pkg::rsp_type got);
      pfe_pkg::rsp_type want;
      if (expected_pairs.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%t: unexpected result first %0d second %0d bad %0b", $realtime,
                     got.first_cipher, got.second_cipher, got.bad_letter);
         return;
      end
      want = expected_pairs.pop_front();
      results_checked++;
      if (got.bad_letter) flagged_seen++;
      if (got.first_cipher !== want.first_cipher || got.second_cipher !== want.second_cipher
          || got.bad_letter !== want.bad_letter) begin
         error_count++;
         if (error_count <= 10)
            $display("%t: result %0d expected first %0d second %0d bad %0b, got %0d %0d %0b",
                     $realtime, results_checked, want.first_cipher, want.second_cipher,
                     want.bad_letter, got.first_cipher, got.second_cipher, got.bad_letter);
      end
   endtask

   // Check the result before taking the new word: a word accepted on this edge cannot
   // have produced the result leaving on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         placed       = '0;
         placed[pfe_pkg::LETTER_J] = 1'b1;
         cells_filled = 0;
         held_letter  = '0;
         held_valid   = 1'b0;
         expected_pairs.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) predict_word(req_data);
      end
      results_waiting = expected_pairs.size();
   end

endmodule

// File: test/playfair_encryptor_tb.sv
// Testbench top for the Playfair encryptor: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module playfair_encryptor_tb;

   localparam int TOTAL_WORDS = 1850;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pfe_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pfe_pkg::rsp_type rsp_data;

   int error_count, results_waiting, results_checked, flagged_seen;

   // calm: both sides run without idling for a stretch of words
   bit calm         = 1'b0;
   int words_sent   = 0;
   int msg_words    = 0;
   int stall_left   = 0;
   bit rsp_taken    = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   playfair_encryptor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   playfair_encryptor_checker score (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .results_waiting (results_waiting),
      .results_checked (results_checked),
      .flagged_seen    (flagged_seen)
   );

   // Receiver: after each accepted result draw a stall; hold ready low for that many
   // cycles of a waiting result, then raise it until the next result is taken.
   always @(posedge clock) rsp_taken <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_taken) stall_left = calm ? 0 : $urandom_range(0, 9);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         if (rsp_valid) stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Sender: idle for a drawn gap, then present the word and hold it until accepted.
   task automatic put_word(pfe_pkg::cmd_type c, logic [pfe_pkg::LETTER_W-1:0] l);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{cmd: c, letter: l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (c == pfe_pkg::CMD_MSG || c == pfe_pkg::CMD_MSG_END) msg_words++;
   endtask

   // Drop valid and hold off until every predicted result has been drained.
   task automatic wait_for_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_waiting != 0) @(negedge clock);
   endtask

   initial begin
      logic [pfe_pkg::LETTER_W-1:0] last_letter;
      int                           pick;
      last_letter = '0;

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Message words before the square exists: drop silently.
      put_word(pfe_pkg::CMD_MSG, 5'd7);
      put_word(pfe_pkg::CMD_MSG_END, 5'd0);

      // Key PLAYF with a repeat A, a J, an out-of-range letter, then R E X Z.
      // Square: PLAYF / REXZB / CDGHI / KMNOQ / STUVW
      put_word(pfe_pkg::CMD_KEY, 5'd15);
      put_word(pfe_pkg::CMD_KEY, 5'd11);
      put_word(pfe_pkg::CMD_KEY, 5'd0);
      put_word(pfe_pkg::CMD_KEY, 5'd24);
      put_word(pfe_pkg::CMD_KEY, 5'd5);
      put_word(pfe_pkg::CMD_KEY, 5'd0);
      put_word(pfe_pkg::CMD_KEY, pfe_pkg::LETTER_J);
      put_word(pfe_pkg::CMD_KEY, 5'd31);
      put_word(pfe_pkg::CMD_KEY, 5'd17);
      put_word(pfe_pkg::CMD_KEY, 5'd4);
      put_word(pfe_pkg::CMD_KEY, pfe_pkg::LETTER_X);
      put_word(pfe_pkg::CMD_KEY, 5'd25);
      put_word(pfe_pkg::CMD_KEY_END, 5'd0);
      // Repeated key end and key letters into a full square: no effect.
      put_word(pfe_pkg::CMD_KEY_END, 5'd31);
      put_word(pfe_pkg::CMD_KEY, 5'd2);

      // Same row (P L), same column (P R).
      put_word(pfe_pkg::CMD_MSG, 5'd15);
      put_word(pfe_pkg::CMD_MSG, 5'd11);
      put_word(pfe_pkg::CMD_MSG, 5'd15);
      put_word(pfe_pkg::CMD_MSG, 5'd17);
      // Doubled E: pad with X, E stays held across the dropped J and letter 26.
      put_word(pfe_pkg::CMD_MSG, 5'd4);
      put_word(pfe_pkg::CMD_MSG, 5'd4);
      put_word(pfe_pkg::CMD_MSG, pfe_pkg::LETTER_J);
      put_word(pfe_pkg::CMD_MSG, 5'd26);
      put_word(pfe_pkg::CMD_MSG_END, 5'd0);
      // XX becomes XQ, the held X is padded at message end, then an empty message end.
      put_word(pfe_pkg::CMD_MSG, pfe_pkg::LETTER_X);
      put_word(pfe_pkg::CMD_MSG, pfe_pkg::LETTER_X);
      put_word(pfe_pkg::CMD_MSG_END, 5'd0);
      put_word(pfe_pkg::CMD_MSG_END, 5'd31);

      // Random traffic: mostly well-formed message letters, with doubles, X runs,
      // bad letters, message ends and ignored key words mixed in.
      while (words_sent < TOTAL_WORDS) begin
         if (words_sent % 150 == 0) calm = ($urandom_range(0, 2) == 0);
         if (words_sent == TOTAL_WORDS / 2) wait_for_results();
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            put_word(pfe_pkg::CMD_KEY, pfe_pkg::LETTER_W'($urandom_range(0, 31)));
         end else if (pick < 5) begin
            put_word(pfe_pkg::CMD_KEY_END, pfe_pkg::LETTER_W'($urandom_range(0, 31)));
         end else if (pick < 13) begin
            put_word(pfe_pkg::CMD_MSG_END, pfe_pkg::LETTER_W'($urandom_range(0, 31)));
         end else if (pick < 17) begin
            put_word(pfe_pkg::CMD_MSG,
                     ($urandom_range(0, 1) == 0) ? pfe_pkg::LETTER_J
                                                 : pfe_pkg::LETTER_W'($urandom_range(26, 31)));
         end else begin
            if (pick < 30) begin
               // repeat the previous letter to force a doubled digraph
            end else if (pick < 36) begin
               last_letter = pfe_pkg::LETTER_X;
            end else begin
               last_letter = pfe_pkg::LETTER_W'($urandom_range(0, pfe_pkg::ALPHABET - 1));
            end
            put_word(pfe_pkg::CMD_MSG, last_letter);
         end
      end

      wait_for_results();
      repeat (40) @(negedge clock);

      $display("Sent %0d words, %0d of them message words, one fixed key square.",
               words_sent, msg_words);
      $display("Checked %0d digraph results, %0d of them flagged dropped letters.",
               results_checked, flagged_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the handshakes hang.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
